/* rtl/pilsc_pkg.sv */
// Package for the packed implicit-length string compare.
// Payload structs, mode field codes and a shared helper function; no dependencies.
`timescale 1ns / 1ps
package pilsc_pkg;

  typedef enum logic [1:0] {
    AGG_EQUAL_ANY     = 2'd0,
    AGG_RANGES        = 2'd1,
    AGG_EQUAL_EACH    = 2'd2,
    AGG_EQUAL_ORDERED = 2'd3
  } agg_e;

  typedef enum logic [1:0] {
    POL_POS      = 2'd0,
    POL_NEG      = 2'd1,
    POL_POS_MASK = 2'd2,
    POL_NEG_MASK = 2'd3
  } pol_e;

  typedef struct packed {
    logic [6:0]  mode;
    logic [63:0] first_low;
    logic [63:0] first_high;
    logic [63:0] second_low;
    logic [63:0] second_high;
  } in_t;

  typedef struct packed {
    logic [15:0] match_mask;
    logic [4:0]  match_index;
    logic        zero_flag;
    logic        sign_flag;
    logic        carry_flag;
    logic        overflow_flag;
  } out_t;

  // Element i of a 128-bit operand, zero-extended to 16 bits.
  function automatic logic [15:0] elem(input logic [127:0] v, input logic words,
                                       input logic [3:0] i);
    logic [15:0] r;
    if (words) r = v[{i[2:0], 4'd0} +: 16];
    else       r = {8'd0, v[{i, 3'd0} +: 8]};
    return r;
  endfunction

endpackage

/* rtl/pilsc_cmp.sv */
// Comparator matrix stage for the string compare: 16x16 equality and range bits.
// Depends on pilsc_pkg.
`timescale 1ns / 1ps
module pilsc_cmp (
  input  logic [127:0] a_i,
  input  logic [127:0] b_i,
  input  logic         words_i,
  input  logic         sgn_i,
  output logic [15:0]  eq_o [16],
  output logic [15:0]  ge_o [16],
  output logic [15:0]  le_o [16]
);
  import pilsc_pkg::*;

  logic [15:0] flip;
  assign flip = sgn_i ? (words_i ? 16'h8000 : 16'h0080) : 16'h0000;

  // eq[j][i]: b[j]==a[i]; ge[j][i]: b[j]>=a[i]; le[j][i]: b[j]<=a[i]
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int i = 0; i < 16; i++) begin
        eq_o[j][i] = elem(b_i, words_i, 4'(j)) == elem(a_i, words_i, 4'(i));
        ge_o[j][i] = (elem(b_i, words_i, 4'(j)) ^ flip) >= (elem(a_i, words_i, 4'(i)) ^ flip);
        le_o[j][i] = (elem(b_i, words_i, 4'(j)) ^ flip) <= (elem(a_i, words_i, 4'(i)) ^ flip);
      end
    end
  end

endmodule

/* rtl/packed_implicit_length_string_compare_top.sv */
// Pipeline stages, in order: compare, aggregate, polarity, index; each ends in a register.
// Throughput: one beat per cycle; the pipeline advances whenever the output is not stalled.
// The 16x16 comparator matrix sets the depth of the first stage.
// Reset clears all stage valid bits; payload registers are not reset.
// No state survives between items.
// Depends on pilsc_pkg and pilsc_cmp.
`timescale 1ns / 1ps
module packed_implicit_length_string_compare_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pilsc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pilsc_pkg::out_t out_data_o
);
  import pilsc_pkg::*;

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage 0: lengths and comparator matrix
  logic [127:0] a, b;
  logic [15:0]  va, vb;
  logic [15:0]  eq [16];
  logic [15:0]  ge [16];
  logic [15:0]  le [16];
  logic         words;
  assign a     = {in_data_i.first_high, in_data_i.first_low};
  assign b     = {in_data_i.second_high, in_data_i.second_low};
  assign words = in_data_i.mode[0];

  // valid element masks: prefix of nonzero elements
  always_comb begin
    logic pa, pb;
    pa = 1'b1;
    pb = 1'b1;
    for (int i = 0; i < 16; i++) begin
      pa = pa && (elem(a, words, 4'(i)) != 16'd0) && (!words || i < 8);
      pb = pb && (elem(b, words, 4'(i)) != 16'd0) && (!words || i < 8);
      va[i] = pa;
      vb[i] = pb;
    end
  end

  pilsc_cmp u_cmp (
    .a_i(a), .b_i(b), .words_i(words), .sgn_i(in_data_i.mode[1]),
    .eq_o(eq), .ge_o(ge), .le_o(le)
  );

  logic        s1_valid_q;
  logic [6:0]  s1_mode_q;
  logic [15:0] s1_va_q, s1_vb_q;
  logic [15:0] s1_eq_q [16];
  logic [15:0] s1_ge_q [16];
  logic [15:0] s1_le_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q <= in_data_i.mode;
      s1_va_q   <= va;
      s1_vb_q   <= vb;
      s1_eq_q   <= eq;
      s1_ge_q   <= ge;
      s1_le_q   <= le;
    end
  end

  // stage 1: aggregation
  logic [15:0] all1, res1;
  assign all1 = s1_mode_q[0] ? 16'h00FF : 16'hFFFF;
  always_comb begin
    logic bit_v;
    res1 = '0;
    for (int j = 0; j < 16; j++) begin
      bit_v = 1'b0;
      unique case (agg_e'(s1_mode_q[3:2]))
        AGG_EQUAL_ANY: bit_v = s1_vb_q[j] && |(s1_eq_q[j] & s1_va_q);
        AGG_RANGES: begin
          for (int p = 0; p < 8; p++)
            if (s1_va_q[2*p+1] && s1_ge_q[j][2*p] && s1_le_q[j][2*p+1]) bit_v = 1'b1;
          bit_v = bit_v && s1_vb_q[j];
        end
        AGG_EQUAL_EACH:
          bit_v = (s1_va_q[j] && s1_vb_q[j]) ? s1_eq_q[j][j] : (!s1_va_q[j] && !s1_vb_q[j]);
        default: begin
          bit_v = 1'b1;
          for (int i = 0; i < 16; i++)
            if (i + j < 16 && all1[i+j] && s1_va_q[i] &&
                (!s1_vb_q[i+j] || !s1_eq_q[i+j][i])) bit_v = 1'b0;
        end
      endcase
      res1[j] = bit_v;
    end
  end

  logic        s2_valid_q;
  logic [6:0]  s2_mode_q;
  logic [15:0] s2_res_q, s2_vb_q;
  logic        s2_sf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mode_q <= s1_mode_q;
      s2_res_q  <= res1 & all1;
      s2_vb_q   <= s1_vb_q;
      s2_sf_q   <= s1_mode_q[0] ? !s1_va_q[7] : !s1_va_q[15];
    end
  end

  // stage 2: polarity
  logic [15:0] all2, res2;
  assign all2 = s2_mode_q[0] ? 16'h00FF : 16'hFFFF;
  always_comb begin
    unique case (pol_e'(s2_mode_q[5:4]))
      POL_NEG:      res2 = s2_res_q ^ all2;
      POL_NEG_MASK: res2 = s2_res_q ^ s2_vb_q;
      default:      res2 = s2_res_q;
    endcase
  end

  logic        s3_valid_q;
  logic [6:0]  s3_mode_q;
  logic [15:0] s3_res_q;
  logic        s3_zf_q, s3_sf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else if (adv) s3_valid_q <= s2_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mode_q <= s2_mode_q;
      s3_res_q  <= res2 & all2;
      s3_zf_q   <= s2_mode_q[0] ? !s2_vb_q[7] : !s2_vb_q[15];
      s3_sf_q   <= s2_sf_q;
    end
  end

  // stage 3: index and flags
  logic [4:0] idx;
  always_comb begin
    idx = s3_mode_q[0] ? 5'd8 : 5'd16;
    if (s3_mode_q[6]) begin
      for (int i = 0; i < 16; i++) if (s3_res_q[i]) idx = 5'(i);
    end else begin
      for (int i = 15; i >= 0; i--) if (s3_res_q[i]) idx = 5'(i);
    end
  end

  logic out_valid_q;
  out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= s3_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.match_mask    <= s3_res_q;
      out_q.match_index   <= idx;
      out_q.zero_flag     <= s3_zf_q;
      out_q.sign_flag     <= s3_sf_q;
      out_q.carry_flag    <= |s3_res_q;
      out_q.overflow_flag <= s3_res_q[0];
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mask_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_mode_q[0] |-> s3_res_q[15:8] == 8'd0)
    else $error("upper mask bits set in word mode");
  a_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.carry_flag == (out_data_o.match_mask != 16'd0))
    else $error("carry flag disagrees with mask");
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.carry_flag |-> out_data_o.match_index < 5'd16)
    else $error("index out of range for nonempty mask");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

/* tb/sv/packed_implicit_length_string_compare_top_test.sv */
// Testbench for packed_implicit_length_string_compare_top: directed and random string compares
// checked against an in-bench predictor through a small scoreboard. Depends on pilsc_pkg.
`timescale 1ns / 1ps
module packed_implicit_length_string_compare_top_test;
  import pilsc_pkg::*;

  class compare_scoreboard;
    out_t expected_q[$];
    int errors;
    int checked;

    function automatic logic [15:0] elem_of(logic [127:0] v, bit words, int i);
      if (words) return v[i*16 +: 16];
      return {8'd0, v[i*8 +: 8]};
    endfunction

    function automatic int length_of(logic [127:0] v, bit words, int n);
      for (int i = 0; i < n; i++) if (elem_of(v, words, i) == 16'd0) return i;
      return n;
    endfunction

    function automatic out_t predict_compare(in_t b);
      logic [127:0] a, s;
      bit words, sgn, msb, bit_r, va, vb;
      agg_e agg;
      pol_e pol;
      int n, len1, len2, idx;
      logic [15:0] flip, all, v2, res, lo, hi, x;
      out_t r;
      a = {b.first_high, b.first_low};
      s = {b.second_high, b.second_low};
      words = b.mode[0];
      sgn = b.mode[1];
      agg = agg_e'(b.mode[3:2]);
      pol = pol_e'(b.mode[5:4]);
      msb = b.mode[6];
      n = words ? 8 : 16;
      all = words ? 16'h00ff : 16'hffff;
      flip = sgn ? (words ? 16'h8000 : 16'h0080) : 16'h0;
      len1 = length_of(a, words, n);
      len2 = length_of(s, words, n);
      v2 = (len2 >= 16) ? 16'hffff : ((16'd1 << len2) - 16'd1);
      res = '0;
      for (int j = 0; j < n; j++) begin
        bit_r = 0;
        case (agg)
          AGG_EQUAL_ANY: begin
            if (j < len2)
              for (int i = 0; i < len1; i++)
                if (elem_of(a, words, i) == elem_of(s, words, j)) bit_r = 1;
          end
          AGG_RANGES: begin
            if (j < len2)
              for (int i = 0; i + 1 < len1; i += 2) begin
                lo = elem_of(a, words, i) ^ flip;
                hi = elem_of(a, words, i + 1) ^ flip;
                x = elem_of(s, words, j) ^ flip;
                if (lo <= x && x <= hi) bit_r = 1;
              end
          end
          AGG_EQUAL_EACH: begin
            va = j < len1;
            vb = j < len2;
            if (va && vb) bit_r = elem_of(a, words, j) == elem_of(s, words, j);
            else bit_r = !va && !vb;
          end
          default: begin
            bit_r = 1;
            for (int i = 0; i < len1 && i + j < n; i++)
              if (i + j >= len2 || elem_of(a, words, i) != elem_of(s, words, i + j)) bit_r = 0;
          end
        endcase
        res[j] = bit_r;
      end
      if (pol == POL_NEG) res ^= all;
      else if (pol == POL_NEG_MASK) res ^= v2;
      res &= all;
      idx = n;
      if (res != 0) begin
        if (msb) begin
          for (int i = 0; i < n; i++) if (res[i]) idx = i;
        end else begin
          for (int i = n - 1; i >= 0; i--) if (res[i]) idx = i;
        end
      end
      r.match_mask = res;
      r.match_index = idx[4:0];
      r.zero_flag = len2 < n;
      r.sign_flag = len1 < n;
      r.carry_flag = res != 0;
      r.overflow_flag = res[0];
      return r;
    endfunction

    function void note_input(in_t b);
      expected_q.push_back(predict_compare(b));
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.match_mask !== exp.match_mask)
        $display("%0t: match_mask exp %h got %h", $time, exp.match_mask, got.match_mask);
      if (got.match_index !== exp.match_index)
        $display("%0t: match_index exp %0d got %0d", $time, exp.match_index, got.match_index);
      if (got.zero_flag !== exp.zero_flag)
        $display("%0t: zero_flag exp %b got %b", $time, exp.zero_flag, got.zero_flag);
      if (got.sign_flag !== exp.sign_flag)
        $display("%0t: sign_flag exp %b got %b", $time, exp.sign_flag, got.sign_flag);
      if (got.carry_flag !== exp.carry_flag)
        $display("%0t: carry_flag exp %b got %b", $time, exp.carry_flag, got.carry_flag);
      if (got.overflow_flag !== exp.overflow_flag)
        $display("%0t: overflow_flag exp %b got %b", $time, exp.overflow_flag,
                 got.overflow_flag);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_t out_data_o;

  compare_scoreboard board;
  bit long_hold_req = 0;
  int sent = 0;

  packed_implicit_length_string_compare_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Random operand with a terminator placed at a random element, or none.
  function automatic logic [127:0] rand_operand(bit words, bit narrow);
    logic [127:0] v;
    int n, cut, e;
    n = words ? 8 : 16;
    v = {$urandom, $urandom, $urandom, $urandom};
    if (narrow) begin
      // small alphabet so equality matches happen often
      for (int i = 0; i < n; i++) begin
        e = $urandom_range(1, 4);
        if (words) v[i*16 +: 16] = ($urandom_range(0, 3) == 0) ? {8'h80, 8'(e)} : 16'(e);
        else v[i*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'(8'h80 | e) : 8'(e);
      end
    end
    cut = $urandom_range(0, n + 4);
    if (cut < n) begin
      if (words) v[cut*16 +: 16] = 16'd0;
      else v[cut*8 +: 8] = 8'd0;
    end
    return v;
  endfunction

  task automatic send_beat(in_t b);
    in_valid_i <= 1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(b);
    sent++;
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_compare(logic [6:0] mode, logic [127:0] a, logic [127:0] s);
    in_t b;
    b.mode = mode;
    {b.first_high, b.first_low} = a;
    {b.second_high, b.second_low} = s;
    send_beat(b);
  endtask

  // Receiver: pseudo-random stall pattern, plus long holds when the sender requests them.
  initial begin
    int pattern;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1;
        repeat (40) @(posedge clk_i);
        long_hold_req = 0;
        out_stall_i <= 0;
      end else begin
        pattern = $urandom_range(0, 99);
        out_stall_i <= (pattern < 30);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [127:0] a, s;
    logic [6:0] mode;
    int burst, wait_cycles;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: all aggregations and polarities, both widths and index ends
    for (int m = 0; m < 16; m++) begin
      mode = 7'(m * 4) | {m[3], 6'd0};
      send_compare(mode | 7'(m % 2), {8{16'h4142}}, {8{16'h4142}});
    end
    send_compare({1'b0, POL_POS, AGG_EQUAL_ANY, 2'b00}, 128'd0, 128'd0);
    send_compare({1'b1, POL_NEG, AGG_EQUAL_EACH, 2'b00}, '1, '1);
    send_compare({1'b0, POL_NEG_MASK, AGG_EQUAL_EACH, 2'b01}, {8{16'hffff}}, 128'h0000_1234);
    send_compare({1'b0, POL_POS, AGG_RANGES, 2'b10}, 128'h7f80, {16{8'h85}});
    send_compare({1'b0, POL_POS, AGG_RANGES, 2'b00}, 128'h7f80, {16{8'h85}});
    send_compare({1'b0, POL_POS, AGG_RANGES, 2'b11}, 128'h7fff_8000, {8{16'h9000}});
    send_compare({1'b1, POL_POS_MASK, AGG_EQUAL_ORDERED, 2'b00}, 128'h6261,
                 128'h6162_6162_6162_6162_6162_6162_6162_6162);
    send_compare({1'b0, POL_POS, AGG_EQUAL_ORDERED, 2'b00}, 128'd0, 128'h41);
    send_compare({1'b0, POL_NEG, AGG_EQUAL_ANY, 2'b01}, 128'h0002_0001, 128'd0);
    idle_gap(1);

    while (sent < 1120) begin
      burst = $urandom_range(1, 20);
      if (sent > 400 && sent < 420) long_hold_req = 1;
      for (int k = 0; k < burst; k++) begin
        mode = 7'($urandom_range(0, 127));
        a = rand_operand(mode[0], $urandom_range(0, 2) != 0);
        s = rand_operand(mode[0], $urandom_range(0, 2) != 0);
        // ordered search often needs the pattern to appear inside the string
        if (mode[3:2] == AGG_EQUAL_ORDERED && $urandom_range(0, 1))
          a = s >> (mode[0] ? 16 * $urandom_range(0, 7) : 8 * $urandom_range(0, 15));
        send_compare(mode, a, s);
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      idle_gap(wait_cycles);
    end
    in_valid_i <= 0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d compares over both widths, all aggregations and polarities;", sent);
    $display("checked %0d results under random stalls and a long output hold.", board.checked);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
